[hdl/signed_int_to_decimal_ascii_macros.svh]
// assertion macros used by the top-level rtl
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SITDA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sitda same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SITDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sitda next-cycle check failed");

`endif

[hdl/sitda_pkg.sv]
package sitda_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned DigitCount = 10;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned BcdW       = DigitCount * DigitW;
  localparam int unsigned StepBits   = 4;
  localparam int unsigned ConvStages = ValueW / StepBits;
  localparam int unsigned CharW      = 6;
  localparam int unsigned IdxW       = $clog2(DigitCount);

  localparam logic [CharW-1:0] AsciiZero  = 6'd48;
  localparam logic [CharW-1:0] AsciiMinus = 6'd45;

  typedef logic [DigitCount-1:0][DigitW-1:0] bcd_t;

  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } bcd_item_t;

  // four double-dabble steps: adjust digits, then shift one binary bit in
  function automatic bcd_t dd_nibble(bcd_t b, logic [StepBits-1:0] bits);
    bcd_t r;
    logic [BcdW-1:0] flat;
    r = b;
    for (int j = 0; j < StepBits; j++) begin
      for (int d = 0; d < DigitCount; d++) begin
        if (r[d] >= 4'd5) begin
          r[d] = r[d] + 4'd3;
        end
      end
      flat = r;
      flat = {flat[BcdW-2:0], bits[StepBits-1-j]};
      r = flat;
    end
    return r;
  endfunction

endpackage

[hdl/sitda_conv.sv]
module sitda_conv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [sitda_pkg::ValueW-1:0] value_i,
  output logic                            item_valid_o,
  input  logic                            item_ready_i,
  output sitda_pkg::bcd_item_t            item_o
);

  localparam int unsigned NS = sitda_pkg::ConvStages;

  logic [NS:0]                   valid_q;
  logic [NS+1:0]                 rdy;
  logic                          neg_q [NS+1];
  logic [sitda_pkg::ValueW-1:0]  mag_q [NS+1];
  sitda_pkg::bcd_t               bcd_q [NS+1];

  assign rdy[NS+1] = item_ready_i;

  for (genvar s = 0; s <= NS; s++) begin : g_rdy
    assign rdy[s] = !valid_q[s] || rdy[s+1];
  end

  assign in_ready_o = rdy[0];

  // input stage: sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      neg_q[0] <= value_i[sitda_pkg::ValueW-1];
      mag_q[0] <= value_i[sitda_pkg::ValueW-1] ? (sitda_pkg::ValueW'(0) - unsigned'(value_i))
                                               : unsigned'(value_i);
      bcd_q[0] <= '0;
    end
  end

  // dabble stages, four bits each
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int unsigned Top = sitda_pkg::ValueW - 1 - (s - 1) * sitda_pkg::StepBits;

    sitda_pkg::bcd_t bcd_d;

    assign bcd_d = sitda_pkg::dd_nibble(bcd_q[s-1], mag_q[s-1][Top -: sitda_pkg::StepBits]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && valid_q[s-1]) begin
        neg_q[s] <= neg_q[s-1];
        mag_q[s] <= mag_q[s-1];
        bcd_q[s] <= bcd_d;
      end
    end
  end

  assign item_valid_o = valid_q[NS];
  assign item_o.neg   = neg_q[NS];
  assign item_o.bcd   = bcd_q[NS];

endmodule

[hdl/sitda_ser.sv]
module sitda_ser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  sitda_pkg::bcd_item_t            item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sitda_pkg::CharW-1:0]     char_code_o,
  output logic                            last_char_o
);

  logic                          busy_q, busy_d;
  logic                          neg_q, neg_d;
  logic [sitda_pkg::IdxW-1:0]    idx_q, idx_d;
  sitda_pkg::bcd_t               bcd_q, bcd_d;
  logic                          ov_q, ov_d;
  logic [sitda_pkg::CharW-1:0]   ch_q, ch_d;
  logic                          last_q, last_d;
  logic [sitda_pkg::IdxW-1:0]    top_idx;

  // most significant nonzero digit, zero maps to the lowest digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < sitda_pkg::DigitCount; d++) begin
      if (item_i.bcd[d] != '0) begin
        top_idx = sitda_pkg::IdxW'(d);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    idx_d  = idx_q;
    bcd_d  = bcd_q;
    ov_d   = ov_q;
    ch_d   = ch_q;
    last_d = last_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    if (!busy_q) begin
      if (item_valid_i) begin
        busy_d = 1'b1;
        neg_d  = item_i.neg;
        bcd_d  = item_i.bcd;
        idx_d  = top_idx;
      end
    end else if (!ov_q || out_ready_i) begin
      ov_d = 1'b1;
      if (neg_q) begin
        ch_d   = sitda_pkg::AsciiMinus;
        last_d = 1'b0;
        neg_d  = 1'b0;
      end else begin
        ch_d   = sitda_pkg::AsciiZero + {2'b00, bcd_q[idx_q]};
        last_d = (idx_q == '0);
        if (idx_q == '0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      neg_q  <= neg_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    bcd_q  <= bcd_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign item_ready_o = !busy_q;
  assign out_valid_o  = ov_q;
  assign char_code_o  = ch_q;
  assign last_char_o  = last_q;

endmodule

[hdl/signed_int_to_decimal_ascii.sv]
// Converts a signed 32-bit integer into its decimal ASCII text, one character per output
// request: an optional '-' (45), then the digits '0'..'9' (48..57) most significant first
// with no leading zeros, last_char_o marking the final one; zero gives "0" and the most
// negative value gives "-2147483648". Each input request passes a nine-stage binary-to-BCD
// pipeline (sign/magnitude, then eight stages of four double-dabble steps), then the character
// serializer, which loads a number and then emits its characters in turn; it takes no new
// number until it has registered the last character of the current one, so it sets the
// sustained rate; the pipeline keeps up to nine further numbers queued behind it.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sitda_pkg::ValueW-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sitda_pkg::CharW-1:0]         char_code_o,
  output logic                                last_char_o
);

  logic                 item_valid;
  logic                 item_ready;
  sitda_pkg::bcd_item_t item;
  logic                 char_is_minus;
  logic                 char_is_zero;
  logic                 char_is_digit;
  logic                 minus_taken;

  sitda_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  sitda_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  assign char_is_minus = (char_code_o == sitda_pkg::AsciiMinus);
  assign char_is_zero  = (char_code_o == sitda_pkg::AsciiZero);
  assign char_is_digit = (char_code_o >= sitda_pkg::AsciiZero) &&
                         (char_code_o <= sitda_pkg::AsciiZero + 6'd9);
  assign minus_taken   = out_valid_o && out_ready_i && char_is_minus;

  `SITDA_ASSERT_SAME(a_char_range, out_valid_o, char_is_minus || char_is_digit)
  `SITDA_ASSERT_SAME(a_minus_not_last, out_valid_o && char_is_minus, !last_char_o)
  `SITDA_ASSERT_NEXT(a_no_zero_after_minus, minus_taken, !(out_valid_o && char_is_zero))

endmodule

[test/tb.sv]
module tb;
  import sitda_pkg::*;

  localparam int unsigned ClockLimit  = 600000;
  localparam int unsigned RandomCount = 138;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned Base        = 10;

  class dec_text_scoreboard;
    typedef struct {
      logic [CharW-1:0] code;
      logic             last;
    } text_char_t;

    text_char_t expected_chars[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // turn one accepted integer into the characters it should print
    function void note_value(logic signed [ValueW-1:0] value);
      logic [ValueW-1:0] magnitude;
      logic [3:0]        digits[$];
      text_char_t        c;
      magnitude = value[ValueW-1] ? (32'd0 - value) : value;
      do begin
        digits.push_front(4'(magnitude % Base));
        magnitude = magnitude / Base;
      end while (magnitude != 0);
      if (value[ValueW-1]) begin
        c.code = AsciiMinus;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.code = AsciiZero + CharW'(digits[i]);
        c.last = (i == digits.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CharW-1:0] code, logic last);
      text_char_t c;
      if (expected_chars.size() == 0) begin
        $error("unexpected character code %0d last %0d", code, last);
        mismatches++;
      end else begin
        c = expected_chars.pop_front();
        if (code !== c.code) begin
          $error("char_code expected %0d actual %0d", c.code, code);
          mismatches++;
        end
        if (last !== c.last) begin
          $error("last_char expected %0d actual %0d", c.last, last);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [CharW-1:0]         char_code_o;
  logic                     last_char_o;

  dec_text_scoreboard text_sb;
  int unsigned        cycle_count;
  bit                 hold_request;

  signed_int_to_decimal_ascii u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= ClockLimit) begin
      $display("FAIL signed_int_to_decimal_ascii");
      $finish;
    end
  end

  // random idle gap, with windows that have no idling on either side
  function automatic int pick_gap();
    int r;
    if ((cycle_count / 256) % 4 == 1) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic longint ten_to(int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * Base;
    end
    return p;
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndigits;
    bit     neg;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: begin
        return $urandom;
      end
      1: begin
        ndigits = $urandom_range(1, 10);
        lo = (ndigits == 1) ? 0 : ten_to(ndigits - 1);
        hi = ten_to(ndigits) - 1;
        if (hi > 64'sd2147483647) begin
          hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        end
        mag = lo + (longint'($urandom) % (hi - lo + 1));
      end
      2: begin
        mag = $urandom_range(0, 20);
      end
      default: begin
        // just around a power of ten or a limit
        mag = ten_to($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 3) == 0) begin
          mag = 64'sd2147483647 - $urandom_range(0, 3) + neg;
        end
      end
    endcase
    if (neg) begin
      mag = -mag;
    end
    return mag[ValueW-1:0];
  endfunction

  task automatic send_value(logic [ValueW-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    text_sb.note_value(value);
  endtask

  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        text_sb.check_char(char_code_o, last_char_o);
      end
      if (hold_request) begin
        stall_left   = LongHold;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic [ValueW-1:0] directed[$];
    text_sb      = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    cycle_count  = 0;
    hold_request = 1'b0;
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7fffffff, 32'h80000000, 32'h80000001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1999999999,
                 32'h55555555, 32'haaaaaaaa, 32'd12345, -32'sd7, 32'h0000ffff,
                 32'hffff0000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_value(directed[i]);
    end
    for (int n = 0; n < RandomCount; n++) begin
      if (n == 20) begin
        hold_request = 1'b1;
      end
      send_value(random_value());
    end
    in_valid_i <= 1'b0;
    while (text_sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sitda_pkg.sv
hdl/sitda_conv.sv
hdl/sitda_ser.sv
hdl/signed_int_to_decimal_ascii.sv
test/tb.sv
